// ===== sv/blid_pkg.sv =====
// Shared types and constants for the boot line identifier extractor.
// Used by the parser, the answer emitter and the top level.
package blid_pkg;

  // Default longest identifier, counting the position that marks it too long
  localparam int ID_MAX_DEF = 16;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CHAR      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD       = 2'd2
  } status_t;

  // Answer request from the parser to the emitter
  typedef struct packed {
    logic    fire;
    status_t kind;
  } answer_t;

  // Byte constants
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Letter of the keyword at a given match position
  function automatic logic [7:0] keyword_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0: c = CH_B;
      2'd1: c = CH_O;
      2'd2: c = CH_O;
      default: c = CH_T;
    endcase
    return c;
  endfunction

  // Uppercase a-z, pass everything else
  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b >= CH_LO_A && b <= CH_LO_Z) c = b - CASE_DIFF;
    return c;
  endfunction

endpackage

// ===== sv/blid_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the data being written when both ports hit the same entry.
module blid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read with write-first bypass
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) rd_data_r <= wr_data;
      else rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/blid_parser.sv =====
// Per-byte parser: keyword match, blank skip, token collection into the buffer.
// Depends on blid_pkg; writes the token buffer and raises answer requests.
module blid_parser
  import blid_pkg::*;
#(
  parameter int ID_MAX = ID_MAX_DEF,
  localparam int DEPTH = ID_MAX - 1,
  localparam int CW = $clog2(ID_MAX),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          end_of_sector,
  output answer_t       ans,
  output logic [CW-1:0] ans_cnt,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_TOKEN  = 2'd2,
    PH_DRAIN  = 2'd3
  } phase_t;

  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  phase_t        phase_r, phase_nxt;
  logic [1:0]    kw_r, kw_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          tl_r, tl_nxt;

  logic [CW-1:0] upd_cnt;
  logic          upd_tl;
  logic          is_blank, is_term, is_sep;
  logic          fire_tok, fire_nf;

  assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_EQ);
  assign is_term  = (data_byte <= CH_SPACE) || (data_byte == CH_SEMI);
  assign is_sep   = (data_byte == CH_BSLASH) || (data_byte == CH_SLASH) ||
                    (data_byte == CH_COLON);

  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = to_upper(data_byte);

  // Advance the parse state for one accepted byte
  always_comb begin
    phase_nxt = phase_r;
    kw_nxt    = kw_r;
    cnt_nxt   = cnt_r;
    tl_nxt    = tl_r;
    upd_cnt   = cnt_r;
    upd_tl    = tl_r;
    fire_tok  = 1'b0;
    fire_nf   = 1'b0;
    wr_en     = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_DRAIN: begin
          if (end_of_sector) phase_nxt = PH_SEARCH;
        end
        PH_SEARCH: begin
          if (end_of_sector) begin
            fire_nf = 1'b1;
            kw_nxt  = 2'd0;
          end else if (data_byte == keyword_char(kw_r)) begin
            if (kw_r == 2'd3) begin
              kw_nxt    = 2'd0;
              phase_nxt = PH_SKIP;
              cnt_nxt   = '0;
              tl_nxt    = 1'b0;
            end else begin
              kw_nxt = kw_r + 2'd1;
            end
          end else begin
            kw_nxt = (data_byte == CH_B) ? 2'd1 : 2'd0;
          end
        end
        default: begin
          if (phase_r == PH_SKIP && is_blank) begin
            if (end_of_sector) begin
              fire_tok  = 1'b1;
              phase_nxt = PH_SEARCH;
            end
          end else if (is_term) begin
            fire_tok  = 1'b1;
            phase_nxt = end_of_sector ? PH_SEARCH : PH_DRAIN;
          end else begin
            // Restart on a separator, else keep the character if room remains
            if (is_sep) begin
              upd_cnt = '0;
              upd_tl  = 1'b0;
            end else if (!tl_r) begin
              if (cnt_r == CNT_FULL) begin
                upd_tl = 1'b1;
              end else begin
                wr_en   = 1'b1;
                upd_cnt = cnt_r + CW'(1);
              end
            end
            cnt_nxt = upd_cnt;
            tl_nxt  = upd_tl;
            if (end_of_sector) begin
              fire_tok  = 1'b1;
              phase_nxt = PH_SEARCH;
            end else begin
              phase_nxt = PH_TOKEN;
            end
          end
        end
      endcase
      // Rearm clears the token on the way back to search
      if (phase_nxt == PH_SEARCH && phase_r != PH_SEARCH) begin
        cnt_nxt = '0;
        tl_nxt  = 1'b0;
        kw_nxt  = 2'd0;
      end
    end
  end

  // Form the answer request
  always_comb begin
    ans.fire = fire_tok || fire_nf;
    ans_cnt  = upd_cnt;
    if (fire_nf) ans.kind = ST_NOT_FOUND;
    else if (upd_cnt == '0 || upd_tl) ans.kind = ST_BAD;
    else ans.kind = ST_CHAR;
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      kw_r    <= 2'd0;
      cnt_r   <= '0;
      tl_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      kw_r    <= kw_nxt;
      cnt_r   <= cnt_nxt;
      tl_r    <= tl_nxt;
    end
  end

endmodule

// ===== sv/blid_emitter.sv =====
// Answer emitter: output register, one pending answer, buffer read sequencing.
// Depends on blid_pkg; reads the token buffer through its registered port.
module blid_emitter
  import blid_pkg::*;
#(
  parameter int ID_MAX = ID_MAX_DEF,
  localparam int DEPTH = ID_MAX - 1,
  localparam int CW = $clog2(ID_MAX),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  answer_t       ans,
  input  logic [CW-1:0] ans_cnt,
  input  logic          out_stall,
  input  logic [7:0]    rd_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output logic          hold,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [7:0]    out_id_char,
  output logic          out_final_item
);

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  logic          final_r, final_nxt;
  logic          busy_r, busy_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  status_t       pend_kind_r, pend_kind_nxt;
  logic [CW-1:0] pend_cnt_r, pend_cnt_nxt;

  logic          slot_free;
  logic          start_go;
  status_t       start_kind;
  logic [CW-1:0] start_cnt;

  assign slot_free = !out_valid_r || !out_stall;
  assign hold      = busy_r || pend_r;

  // Pick the answer to start: a pending one first
  always_comb begin
    start_go   = pend_r || ans.fire;
    start_kind = pend_r ? pend_kind_r : ans.kind;
    start_cnt  = pend_r ? pend_cnt_r : ans_cnt;
  end

  // Load the next result into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    final_nxt     = final_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_kind_nxt = pend_kind_r;
    pend_cnt_nxt  = pend_cnt_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (busy_r) begin
        rd_en         = 1'b1;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_CHAR;
        final_nxt     = (idx_r == cnt_r - CW'(1));
        busy_nxt      = (idx_r != cnt_r - CW'(1));
        idx_nxt       = idx_r + CW'(1);
      end else if (start_go) begin
        out_valid_nxt = 1'b1;
        status_nxt    = start_kind;
        pend_nxt      = 1'b0;
        if (start_kind == ST_CHAR) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          final_nxt = (start_cnt == CW'(1));
          busy_nxt  = (start_cnt != CW'(1));
          idx_nxt   = CW'(1);
          cnt_nxt   = start_cnt;
        end else begin
          final_nxt = 1'b1;
          busy_nxt  = 1'b0;
        end
      end
    end else if (ans.fire) begin
      // Park the new answer until the slot frees
      pend_nxt      = 1'b1;
      pend_kind_nxt = ans.kind;
      pend_cnt_nxt  = ans_cnt;
    end
  end

  // Hold emitter state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
    end
    status_r    <= status_nxt;
    final_r     <= final_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_final_item = final_r;
  assign out_id_char    = (status_r == ST_CHAR) ? rd_data : 8'h00;

endmodule

// ===== sv/boot_line_id_extractor_core.sv =====
// Boot line identifier extractor: takes one sector byte per accepted word and
// answers with the uppercased identifier from the first BOOT line, one character
// per result word with the last flagged, or a single not-found or bad-token word.
// A byte is accepted every cycle while in_stall is low. When an answer of
// n characters starts, the input stalls, also through any output stall, while the
// characters are read one per cycle, output stall permitting, from the single read port of the token
// buffer; a one-result answer does not stall the input unless a second answer
// arrives before the first is taken. No clearing pass is needed after reset.
// Depends on blid_pkg, blid_parser, blid_emitter and blid_ram.
module boot_line_id_extractor_core
  import blid_pkg::*;
#(
  parameter int ID_MAX = ID_MAX_DEF,
  localparam int DEPTH = ID_MAX - 1,
  localparam int CW = $clog2(ID_MAX),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_sector,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_id_char,
  output logic       out_final_item
);

  answer_t       ans;
  logic [CW-1:0] ans_cnt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          hold;
  logic          accept;

  // Stall input while a multi-character answer drains or an answer is parked
  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  blid_parser #(.ID_MAX(ID_MAX)) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_sector (in_end_of_sector),
    .ans           (ans),
    .ans_cnt       (ans_cnt),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  blid_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  blid_emitter #(.ID_MAX(ID_MAX)) u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .ans            (ans),
    .ans_cnt        (ans_cnt),
    .out_stall      (out_stall),
    .rd_data        (rd_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .hold           (hold),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_id_char    (out_id_char),
    .out_final_item (out_final_item)
  );

endmodule

// ===== tb/blid_checker.sv =====
`timescale 1ns / 100ps
// Answer checker for the boot line identifier extractor: follows every accepted
// sector byte, predicts the answer words and compares them with the result channel.
// Depends on blid_pkg for the status codes and byte constants.
module blid_checker
  import blid_pkg::*;
#(
  parameter int ID_MAX = ID_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_sector,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_status,
  input  logic [7:0] out_id_char,
  input  logic       out_final_item,
  output int         mismatch_count,
  output int         pending_words,
  output int         checked_words
);

  typedef enum logic [1:0] {
    SCAN_KEYWORD,
    SKIP_BLANKS,
    IN_TOKEN,
    WAIT_SECTOR_END
  } scan_phase_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] id_char;
    logic       final_item;
  } answer_word_t;

  localparam logic [7:0] KEYWORD [4] = '{CH_B, CH_O, CH_O, CH_T};

  // Parser state as the block should hold it
  scan_phase_t  phase;
  int unsigned  kw_matched;
  logic [7:0]   kept_chars [ID_MAX-1];
  int unsigned  kept_len;
  logic         too_long;

  answer_word_t expected_words[$];
  answer_word_t oldest;

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
    checked_words  = 0;
  end

  task automatic restart_sector();
    kw_matched = 0;
    phase      = SCAN_KEYWORD;
    kept_len   = 0;
    too_long   = 1'b0;
  endtask

  task automatic queue_single(input status_t kind);
    answer_word_t w;
    w.status     = kind;
    w.id_char    = 8'h00;
    w.final_item = 1'b1;
    expected_words.push_back(w);
  endtask

  // Queue the kept identifier, or one bad-token word if it is empty or too long
  task automatic queue_answer();
    answer_word_t w;
    if (kept_len == 0 || too_long) begin
      queue_single(ST_BAD);
    end else begin
      for (int k = 0; k < kept_len; k++) begin
        w.status     = ST_CHAR;
        w.id_char    = kept_chars[k];
        w.final_item = (k + 1 == kept_len);
        expected_words.push_back(w);
      end
    end
  endtask

  // Advance the parser by one sector byte
  task automatic follow_byte(input logic [7:0] b, input logic eos);
    logic [7:0] c;
    case (phase)
      WAIT_SECTOR_END: begin
        if (eos) restart_sector();
      end
      SCAN_KEYWORD: begin
        if (eos) begin
          // a keyword completed on the final byte does not count either
          queue_single(ST_NOT_FOUND);
          restart_sector();
        end else begin
          if (kw_matched < 4 && b == KEYWORD[kw_matched]) kw_matched++;
          else kw_matched = (b == CH_B) ? 1 : 0;
          if (kw_matched == 4) begin
            kw_matched = 0;
            phase      = SKIP_BLANKS;
            kept_len   = 0;
            too_long   = 1'b0;
          end
        end
      end
      default: begin
        if (phase == SKIP_BLANKS && (b == CH_SPACE || b == CH_TAB || b == CH_EQ)) begin
          if (eos) begin
            queue_answer();
            restart_sector();
          end
        end else begin
          phase = IN_TOKEN;
          if (b <= CH_SPACE || b == CH_SEMI) begin
            // token ends: answer now, then drop bytes until sector end
            queue_answer();
            if (eos) restart_sector();
            else phase = WAIT_SECTOR_END;
          end else begin
            if (b == CH_BSLASH || b == CH_SLASH || b == CH_COLON) begin
              kept_len = 0;
              too_long = 1'b0;
            end else if (!too_long) begin
              if (kept_len + 1 >= ID_MAX) begin
                too_long = 1'b1;
              end else begin
                c = (b >= CH_LO_A && b <= CH_LO_Z) ? b - CASE_DIFF : b;
                kept_chars[kept_len] = c;
                kept_len++;
              end
            end
            if (eos) begin
              queue_answer();
              restart_sector();
            end
          end
        end
      end
    endcase
  endtask

  // Predict on accepted input words, compare accepted result words
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_sector();
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) follow_byte(in_data_byte, in_end_of_sector);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no answer pending: status %0d id_char %02h final_item %0b",
                 out_status, out_id_char, out_final_item);
          mismatch_count++;
        end else begin
          oldest = expected_words.pop_front();
          checked_words++;
          if (out_status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_status);
            mismatch_count++;
          end
          if (out_id_char !== oldest.id_char) begin
            $error("id_char: expected %02h, got %02h", oldest.id_char, out_id_char);
            mismatch_count++;
          end
          if (out_final_item !== oldest.final_item) begin
            $error("final_item: expected %0b, got %0b", oldest.final_item, out_final_item);
            mismatch_count++;
          end
        end
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the boot line identifier extractor testbench: clock, reset, sector
// stimulus and receiver stalls. Depends on blid_pkg, blid_checker and the block.
module testbench;
  import blid_pkg::*;

  localparam int ITEM_TARGET = 410;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_sector = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_id_char;
  logic       out_final_item;

  int mismatch_count;
  int pending_words;
  int checked_words;

  int cycle_count = 0;
  int bytes_sent = 0;
  int sectors_sent = 0;
  int boot_sectors = 0;
  int burst_left = 0;
  logic held_off = 1'b0;

  logic [7:0] sector_bytes[$];

  boot_line_id_extractor_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_sector (in_end_of_sector),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_id_char      (out_id_char),
    .out_final_item   (out_final_item)
  );

  blid_checker #(.ID_MAX(ID_MAX_DEF)) answer_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_sector (in_end_of_sector),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_id_char      (out_id_char),
    .out_final_item   (out_final_item),
    .mismatch_count   (mismatch_count),
    .pending_words    (pending_words),
    .checked_words    (checked_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: free stretches, random stalls, and one long hold-off
  initial begin
    int mode;
    int seg_len;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && bytes_sent >= ITEM_TARGET / 3) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(4, 50);
      repeat (seg_len) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until taken; idle between bursts
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_sector <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_sector();
    foreach (sector_bytes[i]) send_byte(sector_bytes[i], i == sector_bytes.size() - 1);
    sectors_sent++;
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) sector_bytes.push_back(s[i]);
  endtask

  // Token byte: mostly letters, now and then a separator, else any token byte
  task automatic add_token_char();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      c = CH_LO_A + 8'($urandom_range(0, 25));
    end else if (r == 4) begin
      case ($urandom_range(0, 2))
        0:       c = CH_BSLASH;
        1:       c = CH_SLASH;
        default: c = CH_COLON;
      endcase
    end else begin
      do c = 8'($urandom_range(8'h21, 8'hFF)); while (c == CH_SEMI);
    end
    sector_bytes.push_back(c);
  endtask

  // Noise leaning toward keyword letters so near misses show up
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return CH_B;
      1:       return CH_O;
      2:       return CH_T;
      3:       return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a sector with a BOOT line and random content around it
  task automatic build_boot_sector();
    int r;
    int tok_len;
    int ending;
    sector_bytes.delete();
    repeat ($urandom_range(0, 6)) sector_bytes.push_back(noise_byte());
    load_text("BOOT");
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0:       sector_bytes.push_back(CH_SPACE);
        1:       sector_bytes.push_back(CH_TAB);
        default: sector_bytes.push_back(CH_EQ);
      endcase
    end
    r = $urandom_range(0, 9);
    if (r == 0) tok_len = 0;
    else if (r <= 6) tok_len = $urandom_range(1, 8);
    else if (r <= 8) tok_len = $urandom_range(ID_MAX_DEF - 3, ID_MAX_DEF + 4);
    else tok_len = $urandom_range(ID_MAX_DEF + 4, ID_MAX_DEF + 14);
    repeat (tok_len) add_token_char();
    // ending zero lets the sector end on the last token byte
    ending = $urandom_range(0, 3);
    if (ending != 0) begin
      if (ending == 1) sector_bytes.push_back(CH_SEMI);
      else sector_bytes.push_back(8'($urandom_range(0, 8'h20)));
      repeat ($urandom_range(0, 4)) sector_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keyword completed on the final byte
    sector_bytes.delete();
    load_text("BOOT");
    send_sector();
    // single byte sector without keyword
    sector_bytes.delete();
    sector_bytes.push_back(8'hFF);
    send_sector();
    // sector ends while skipping blanks
    sector_bytes.delete();
    load_text("BOOT=");
    send_sector();
    // terminator right after blanks, then a byte that is ignored
    sector_bytes.delete();
    load_text("BOOT\t");
    sector_bytes.push_back(8'h00);
    sector_bytes.push_back(8'hFF);
    send_sector();
    // separator restarts the buffer, token ends on the final byte
    sector_bytes.delete();
    load_text("BOOTz:a");
    send_sector();

    // Random sectors, mostly well formed
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) != 0) begin
        build_boot_sector();
        boot_sectors++;
      end else begin
        sector_bytes.delete();
        repeat ($urandom_range(1, 12)) sector_bytes.push_back(noise_byte());
      end
      send_sector();
    end
    in_valid <= 1'b0;

    // Drain the answers still in flight
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d bytes in %0d sectors (%0d built around a BOOT line).",
             bytes_sent, sectors_sent, boot_sectors);
    $display("Checked %0d result words, including a long receiver hold-off.", checked_words);
    if (pending_words != 0)
      $error("answer words never arrived: %0d", pending_words);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
